// ===== design/vfp_pkg.sv =====
// ----------------------------------------------------------------------------
// vfp_pkg
// Shared types and constants of the frame parser: record and error codes,
// frame modes, fixed frame offsets and the controller/datapath interface.
// ----------------------------------------------------------------------------
package vfp_pkg;

  typedef enum logic [2:0] {
    REC_ERROR  = 3'd0,
    REC_HEADER = 3'd1,
    REC_WALL   = 3'd2,
    REC_BOX    = 3'd3,
    REC_GOAL   = 3'd4,
    REC_BOMB   = 3'd5,
    REC_POSE   = 3'd6
  } rec_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_CHECKSUM   = 2'd1,
    ERR_FORMAT     = 2'd2,
    ERR_BOMB_FIELD = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    MODE_MAP_V1 = 2'd0,
    MODE_MAP_V2 = 2'd1,
    MODE_POSE   = 2'd2
  } frame_mode_t;

  localparam logic [1:0] CFG_TYPE_MAP_V1 = 2'd0;
  localparam logic [1:0] CFG_TYPE_MAP_V2 = 2'd1;
  localparam logic [1:0] CFG_TYPE_POSE   = 2'd2;

  localparam logic [7:0] SYNC_A = 8'hA5;
  localparam logic [7:0] SYNC_B = 8'h5A;

  localparam int ADDR_W = 7;

  localparam logic [6:0] V1_LEN        = 7'd60;
  localparam logic [6:0] POSE_LEN      = 7'd26;
  localparam logic [6:0] MAP_BOX_CNT   = 7'd26;
  localparam logic [6:0] V1_GOAL_CNT   = 7'd35;
  localparam logic [6:0] V1_BOMB_CNT   = 7'd44;
  localparam logic [6:0] POSE_BOX_CNT  = 7'd7;
  localparam logic [6:0] POSE_CELL_OFS = 7'd8;
  localparam logic [6:0] WALL_FIRST    = 7'd2;
  localparam logic [6:0] WALL_LAST     = 7'd25;
  localparam logic [6:0] NO_INDEX      = 7'h7F;
  localparam logic [2:0] POSE_BOX_MAX  = 3'd5;
  localparam logic [2:0] POSE_BOMB_MAX = 3'd4;
  localparam logic [3:0] POSE_BOMB_ROOM = 4'd8;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic                rd_zero;
    logic                rd_sweep;
    logic [ADDR_W-1:0]   addr;
    logic                sweep_clr;
    logic                load;
    rec_kind_t           kind;
    err_code_t           err;
    logic [2:0]          slot;
    logic                cell_vld;
    logic                last;
    frame_mode_t         mode;
  } dp_cmd_t;

  typedef struct packed {
    logic       xor_ok;
    logic [2:0] box_cnt;
    logic [2:0] goal_cnt;
    logic [2:0] bomb_cnt;
  } dp_stat_t;

endpackage

// ===== design/vfp_datapath.sv =====
// ----------------------------------------------------------------------------
// vfp_datapath
// Payload store, registered read port, checksum and popcount accumulators,
// byte gather register and the output record register.
// ----------------------------------------------------------------------------
module vfp_datapath #(
  parameter int BOX_SLOTS     = 5,
  parameter int GOAL_SLOTS    = 5,
  parameter int BOMB_SLOTS    = 4,
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  vfp_pkg::dp_cmd_t        cmd,
  input  logic [7:0]              wdata,
  output vfp_pkg::dp_stat_t       stat,
  output logic [2:0]              rec_kind,
  output logic [1:0]              rec_err,
  output logic [2:0]              rec_slot,
  output logic signed [15:0]      rec_x,
  output logic signed [15:0]      rec_y,
  output logic signed [15:0]      rec_heading,
  output logic [63:0]             rec_wall,
  output logic [2:0]              rec_box_total,
  output logic [2:0]              rec_goal_total,
  output logic [2:0]              rec_bomb_total,
  output logic [7:0]              rec_extra,
  output logic                    rec_last
);

  localparam int AW          = $clog2(PAYLOAD_DEPTH);
  localparam int V2_GOAL_CNT = 26 + 1 + 2 * BOX_SLOTS;
  localparam int V2_BOMB_CNT = V2_GOAL_CNT + 1 + 2 * GOAL_SLOTS;

  logic [7:0]  mem [PAYLOAD_DEPTH];
  logic [7:0]  rdata_r;
  logic        rd_vld_r, rd_zero_r, rd_sweep_r;
  logic [6:0]  rd_addr_r;
  logic [7:0]  xor_r, walls_r, box_raw_r, goal_raw_r, bomb_raw_r;
  logic [7:0]  pb_r [7];
  logic [63:0] gather_r;

  logic [7:0]  rbyte;
  logic [2:0]  pose_nb, bomb_m4, box_clamp, goal_clamp, bomb_clamp, pose_nm;
  logic [3:0]  pose_room;
  logic [6:0]  box_idx, goal_idx, bomb_idx;

  assign rbyte   = rd_zero_r ? 8'd0 : rdata_r;
  assign pose_nb = (box_raw_r > 8'(vfp_pkg::POSE_BOX_MAX)) ? vfp_pkg::POSE_BOX_MAX
                                                           : box_raw_r[2:0];

  always_comb begin
    unique case (cmd.mode)
      vfp_pkg::MODE_MAP_V2: begin
        box_idx  = vfp_pkg::MAP_BOX_CNT;
        goal_idx = 7'(V2_GOAL_CNT);
        bomb_idx = 7'(V2_BOMB_CNT);
      end
      vfp_pkg::MODE_POSE: begin
        box_idx  = vfp_pkg::POSE_BOX_CNT;
        goal_idx = vfp_pkg::NO_INDEX;
        bomb_idx = vfp_pkg::POSE_CELL_OFS + 7'({pose_nb, 1'b0});
      end
      default: begin
        box_idx  = vfp_pkg::MAP_BOX_CNT;
        goal_idx = vfp_pkg::V1_GOAL_CNT;
        bomb_idx = vfp_pkg::V1_BOMB_CNT;
      end
    endcase
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.addr[AW-1:0]] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[cmd.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_zero_r  <= cmd.rd_zero;
    rd_sweep_r <= cmd.rd_sweep;
    rd_addr_r  <= cmd.addr;
    if (cmd.sweep_clr) begin
      xor_r   <= 8'd0;
      walls_r <= 8'd0;
    end else if (rd_vld_r && rd_sweep_r) begin
      xor_r <= xor_r ^ rbyte;
      if (rd_addr_r >= vfp_pkg::WALL_FIRST && rd_addr_r <= vfp_pkg::WALL_LAST)
        walls_r <= walls_r + 8'($countones(rbyte));
      if (rd_addr_r < 7'd7) pb_r[rd_addr_r[2:0]] <= rbyte;
      if (rd_addr_r == box_idx) box_raw_r <= rbyte;
      if (rd_addr_r == goal_idx) goal_raw_r <= rbyte;
      if (rd_addr_r == bomb_idx) bomb_raw_r <= rbyte;
    end
    if (rd_vld_r && !rd_sweep_r) gather_r <= {rbyte, gather_r[63:8]};
  end

  // counts: map clamps to slot numbers, pose to its own limits
  assign box_clamp  = (box_raw_r > 8'(BOX_SLOTS)) ? 3'(BOX_SLOTS) : box_raw_r[2:0];
  assign goal_clamp = (goal_raw_r > 8'(GOAL_SLOTS)) ? 3'(GOAL_SLOTS) : goal_raw_r[2:0];
  assign bomb_clamp = (bomb_raw_r > 8'(BOMB_SLOTS)) ? 3'(BOMB_SLOTS) : bomb_raw_r[2:0];
  assign bomb_m4    = (bomb_raw_r > 8'(vfp_pkg::POSE_BOMB_MAX)) ? vfp_pkg::POSE_BOMB_MAX
                                                                : bomb_raw_r[2:0];
  assign pose_room  = vfp_pkg::POSE_BOMB_ROOM - {1'b0, pose_nb};
  assign pose_nm    = ({1'b0, bomb_m4} > pose_room) ? pose_room[2:0] : bomb_m4;

  assign stat.xor_ok   = (xor_r == 8'd0);
  assign stat.box_cnt  = (cmd.mode == vfp_pkg::MODE_POSE) ? pose_nb : box_clamp;
  assign stat.goal_cnt = goal_clamp;
  assign stat.bomb_cnt = (cmd.mode == vfp_pkg::MODE_POSE) ? pose_nm : bomb_clamp;

  // output record register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_kind       <= cmd.kind;
      rec_err        <= cmd.err;
      rec_slot       <= cmd.slot;
      rec_last       <= cmd.last;
      rec_x          <= 16'sd0;
      rec_y          <= 16'sd0;
      rec_heading    <= 16'sd0;
      rec_wall       <= 64'd0;
      rec_box_total  <= 3'd0;
      rec_goal_total <= 3'd0;
      rec_bomb_total <= 3'd0;
      rec_extra      <= 8'd0;
      unique case (cmd.kind)
        vfp_pkg::REC_HEADER: begin
          rec_x          <= {8'd0, pb_r[0]};
          rec_y          <= {8'd0, pb_r[1]};
          rec_box_total  <= stat.box_cnt;
          rec_goal_total <= stat.goal_cnt;
          rec_bomb_total <= stat.bomb_cnt;
          rec_extra      <= walls_r;
        end
        vfp_pkg::REC_WALL: rec_wall <= gather_r;
        vfp_pkg::REC_BOX, vfp_pkg::REC_GOAL, vfp_pkg::REC_BOMB: begin
          if (cmd.cell_vld) begin
            rec_x <= {{8{gather_r[55]}}, gather_r[55:48]};
            rec_y <= {{8{gather_r[63]}}, gather_r[63:56]};
          end else begin
            rec_x <= -16'sd1;
            rec_y <= -16'sd1;
          end
        end
        vfp_pkg::REC_POSE: begin
          rec_x          <= {pb_r[2], pb_r[1]};
          rec_y          <= {pb_r[4], pb_r[3]};
          rec_heading    <= {pb_r[6], pb_r[5]};
          rec_box_total  <= stat.box_cnt;
          rec_bomb_total <= stat.bomb_cnt;
          rec_extra      <= pb_r[0];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/vfp_controller.sv =====
// ----------------------------------------------------------------------------
// vfp_controller
// Sync hunt, frame bookkeeping, type registers and the record sequencer
// that drives the datapath read port and output register.
// ----------------------------------------------------------------------------
module vfp_controller #(
  parameter int BOX_SLOTS     = 5,
  parameter int GOAL_SLOTS    = 5,
  parameter int BOMB_SLOTS    = 4,
  parameter int PAYLOAD_DEPTH = 64,
  parameter int WALL_BYTES    = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output vfp_pkg::dp_cmd_t  cmd,
  input  vfp_pkg::dp_stat_t stat
);

  localparam int V2_GOAL_CNT = 26 + 1 + 2 * BOX_SLOTS;
  localparam int V2_BOMB_CNT = V2_GOAL_CNT + 1 + 2 * GOAL_SLOTS;
  localparam int V2_LEN      = V2_BOMB_CNT + 1 + 2 * BOMB_SLOTS + 7;
  localparam int WALL_WORDS  = (WALL_BYTES + 7) / 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_SEQ, ST_GATHER, ST_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_H0, PH_H1, PH_TYPE, PH_DATA} phase_t;

  typedef enum logic [2:0] {
    GRP_HDR, GRP_WALL, GRP_BOX, GRP_GOAL, GRP_BOMB, GRP_POSE
  } group_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  group_t               grp_r, grp_nxt;
  vfp_pkg::frame_mode_t mode_r, mode_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [6:0]           cnt_r, cnt_nxt, exp_r, exp_nxt, addr_r, addr_nxt;
  logic [7:0]           cfg_v1_r, cfg_v1_nxt, cfg_v2_r, cfg_v2_nxt;
  logic [7:0]           cfg_pose_r, cfg_pose_nxt;
  logic [2:0]           idx_r, idx_nxt, k_r, k_nxt;
  logic                 wait_r, wait_nxt, sweep_r, sweep_nxt, last_r, last_nxt;

  vfp_pkg::frame_mode_t fin_mode;
  logic                 fin_hit, fin_ok;
  logic [6:0]           len_cur, fin_len, cnt_inc, rec_base, gather_addr, wall_pos;
  logic [2:0]           grp_last_idx, grp_count, k_last;
  vfp_pkg::rec_kind_t   cur_kind;
  logic                 cur_last;

  function automatic logic [6:0] len_of(input vfp_pkg::frame_mode_t m);
    unique case (m)
      vfp_pkg::MODE_MAP_V2: len_of = 7'(V2_LEN);
      vfp_pkg::MODE_POSE:   len_of = vfp_pkg::POSE_LEN;
      default:              len_of = vfp_pkg::V1_LEN;
    endcase
  endfunction

  // type match at the last byte: registers may have changed mid-frame
  always_comb begin
    fin_hit  = 1'b1;
    fin_mode = vfp_pkg::MODE_MAP_V1;
    priority if (type_r == cfg_v1_r) fin_mode = vfp_pkg::MODE_MAP_V1;
    else if (type_r == cfg_v2_r)     fin_mode = vfp_pkg::MODE_MAP_V2;
    else if (type_r == cfg_pose_r)   fin_mode = vfp_pkg::MODE_POSE;
    else                             fin_hit  = 1'b0;
  end

  assign fin_len = len_of(fin_mode);
  assign fin_ok  = fin_hit && (exp_r == fin_len);
  assign len_cur = len_of(mode_r);
  assign cnt_inc = cnt_r + 7'd1;

  // current record of the run
  always_comb begin
    rec_base     = 7'd0;
    grp_last_idx = 3'd0;
    grp_count    = 3'd0;
    cur_kind     = vfp_pkg::REC_HEADER;
    unique case (grp_r)
      GRP_HDR: cur_kind = vfp_pkg::REC_HEADER;
      GRP_WALL: begin
        cur_kind     = vfp_pkg::REC_WALL;
        rec_base     = vfp_pkg::WALL_FIRST + {1'b0, idx_r, 3'b000};
        grp_last_idx = 3'(WALL_WORDS - 1);
      end
      GRP_BOX: begin
        cur_kind     = vfp_pkg::REC_BOX;
        grp_last_idx = 3'(BOX_SLOTS - 1);
        grp_count    = stat.box_cnt;
        rec_base     = ((mode_r == vfp_pkg::MODE_POSE) ? vfp_pkg::POSE_CELL_OFS
                                                       : vfp_pkg::MAP_BOX_CNT + 7'd1)
                       + {3'b000, idx_r, 1'b0};
      end
      GRP_GOAL: begin
        cur_kind     = vfp_pkg::REC_GOAL;
        grp_last_idx = 3'(GOAL_SLOTS - 1);
        grp_count    = stat.goal_cnt;
        rec_base     = ((mode_r == vfp_pkg::MODE_MAP_V2) ? 7'(V2_GOAL_CNT + 1)
                                                         : vfp_pkg::V1_GOAL_CNT + 7'd1)
                       + {3'b000, idx_r, 1'b0};
      end
      GRP_BOMB: begin
        cur_kind     = vfp_pkg::REC_BOMB;
        grp_last_idx = 3'(BOMB_SLOTS - 1);
        grp_count    = stat.bomb_cnt;
        unique case (mode_r)
          vfp_pkg::MODE_POSE:
            rec_base = vfp_pkg::POSE_CELL_OFS + 7'd1 + 7'({stat.box_cnt, 1'b0});
          vfp_pkg::MODE_MAP_V2: rec_base = 7'(V2_BOMB_CNT + 1);
          default:              rec_base = vfp_pkg::V1_BOMB_CNT + 7'd1;
        endcase
        rec_base = rec_base + {3'b000, idx_r, 1'b0};
      end
      GRP_POSE: cur_kind = vfp_pkg::REC_POSE;
      default: ;
    endcase
  end

  assign cur_last    = (grp_r == GRP_POSE) ||
                       (grp_r == GRP_BOMB && mode_r != vfp_pkg::MODE_POSE &&
                        idx_r == grp_last_idx);
  assign gather_addr = rec_base + {4'd0, k_r};
  assign wall_pos    = {1'b0, idx_r, 3'b000} + {4'd0, k_r};
  assign k_last      = (grp_r == GRP_WALL) ? 3'd7 : 3'd1;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    grp_nxt      = grp_r;
    mode_nxt     = mode_r;
    type_nxt     = type_r;
    cnt_nxt      = cnt_r;
    exp_nxt      = exp_r;
    addr_nxt     = addr_r;
    idx_nxt      = idx_r;
    k_nxt        = k_r;
    wait_nxt     = wait_r;
    sweep_nxt    = sweep_r;
    last_nxt     = last_r;
    cfg_v1_nxt   = cfg_v1_r;
    cfg_v2_nxt   = cfg_v2_r;
    cfg_pose_nxt = cfg_pose_r;
    cmd          = '0;
    cmd.mode     = mode_r;
    cmd.kind     = vfp_pkg::REC_ERROR;
    cmd.err      = vfp_pkg::ERR_NONE;

    if (cfg_we) begin
      unique case (cfg_index)
        vfp_pkg::CFG_TYPE_MAP_V1: cfg_v1_nxt   = cfg_wdata;
        vfp_pkg::CFG_TYPE_MAP_V2: cfg_v2_nxt   = cfg_wdata;
        vfp_pkg::CFG_TYPE_POSE:   cfg_pose_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (phase_r)
            PH_H0: if (in_rx_byte == vfp_pkg::SYNC_A) phase_nxt = PH_H1;
            PH_H1: begin
              if (in_rx_byte == vfp_pkg::SYNC_B) phase_nxt = PH_TYPE;
              else if (in_rx_byte != vfp_pkg::SYNC_A) phase_nxt = PH_H0;
            end
            PH_TYPE: begin
              type_nxt  = in_rx_byte;
              cnt_nxt   = 7'd0;
              phase_nxt = PH_DATA;
              priority if (in_rx_byte == cfg_v1_r) begin
                exp_nxt  = vfp_pkg::V1_LEN;
                mode_nxt = vfp_pkg::MODE_MAP_V1;
              end else if (in_rx_byte == cfg_v2_r) begin
                exp_nxt  = 7'(V2_LEN);
                mode_nxt = vfp_pkg::MODE_MAP_V2;
              end else if (in_rx_byte == cfg_pose_r) begin
                exp_nxt  = vfp_pkg::POSE_LEN;
                mode_nxt = vfp_pkg::MODE_POSE;
              end else begin
                phase_nxt = PH_H0;
                cmd.load  = 1'b1;
                cmd.err   = vfp_pkg::ERR_FORMAT;
                cmd.last  = 1'b1;
                last_nxt  = 1'b1;
                state_nxt = ST_OUT;
              end
            end
            PH_DATA: begin
              if (cnt_r >= 7'(PAYLOAD_DEPTH)) begin
                // store full: drop the byte
                phase_nxt = PH_H0;
                cmd.load  = 1'b1;
                cmd.err   = vfp_pkg::ERR_FORMAT;
                cmd.last  = 1'b1;
                last_nxt  = 1'b1;
                state_nxt = ST_OUT;
              end else begin
                cmd.wr_en = 1'b1;
                cmd.addr  = cnt_r;
                cnt_nxt   = cnt_inc;
                if (cnt_inc >= exp_r) begin
                  phase_nxt = PH_H0;
                  if (fin_ok) begin
                    mode_nxt      = fin_mode;
                    cmd.sweep_clr = 1'b1;
                    addr_nxt      = 7'd0;
                    state_nxt     = ST_SWEEP;
                  end else begin
                    cmd.load  = 1'b1;
                    cmd.err   = vfp_pkg::ERR_FORMAT;
                    cmd.last  = 1'b1;
                    last_nxt  = 1'b1;
                    state_nxt = ST_OUT;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SWEEP: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sweep = 1'b1;
        cmd.addr     = addr_r;
        addr_nxt     = addr_r + 7'd1;
        if (addr_r == len_cur - 7'd1) begin
          sweep_nxt = 1'b1;
          wait_nxt  = 1'b0;
          state_nxt = ST_WAIT;
        end
      end

      ST_SEQ: begin
        k_nxt = 3'd0;
        unique case (grp_r)
          GRP_WALL: state_nxt = ST_GATHER;
          GRP_BOX, GRP_GOAL, GRP_BOMB: begin
            if (idx_r < grp_count) begin
              state_nxt = ST_GATHER;
            end else begin
              cmd.load  = 1'b1;
              cmd.kind  = cur_kind;
              cmd.slot  = idx_r;
              cmd.last  = cur_last;
              last_nxt  = cur_last;
              state_nxt = ST_OUT;
            end
          end
          default: begin
            cmd.load  = 1'b1;
            cmd.kind  = cur_kind;
            cmd.slot  = idx_r;
            cmd.last  = cur_last;
            last_nxt  = cur_last;
            state_nxt = ST_OUT;
          end
        endcase
      end

      ST_GATHER: begin
        cmd.rd_en   = 1'b1;
        cmd.addr    = gather_addr;
        // pad a short last wall word with zero
        cmd.rd_zero = (grp_r == GRP_WALL) && (wall_pos >= 7'(WALL_BYTES));
        k_nxt       = k_r + 3'd1;
        if (k_r == k_last) begin
          sweep_nxt = 1'b0;
          wait_nxt  = 1'b0;
          state_nxt = ST_WAIT;
        end
      end

      ST_WAIT: begin
        // wait for the read register, then accumulate/shift
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (sweep_r) begin
          if (!stat.xor_ok) begin
            cmd.load  = 1'b1;
            cmd.err   = vfp_pkg::ERR_CHECKSUM;
            cmd.last  = 1'b1;
            last_nxt  = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            grp_nxt   = (mode_r == vfp_pkg::MODE_POSE) ? GRP_BOX : GRP_HDR;
            idx_nxt   = 3'd0;
            state_nxt = ST_SEQ;
          end
        end else begin
          cmd.load     = 1'b1;
          cmd.kind     = cur_kind;
          cmd.slot     = idx_r;
          cmd.cell_vld = 1'b1;
          cmd.last     = cur_last;
          last_nxt     = cur_last;
          state_nxt    = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SEQ;
            if (idx_r == grp_last_idx) begin
              idx_nxt = 3'd0;
              unique case (grp_r)
                GRP_HDR:  grp_nxt = GRP_WALL;
                GRP_WALL: grp_nxt = GRP_BOX;
                GRP_BOX:  grp_nxt = (mode_r == vfp_pkg::MODE_POSE) ? GRP_BOMB : GRP_GOAL;
                GRP_GOAL: grp_nxt = GRP_BOMB;
                default:  grp_nxt = GRP_POSE;
              endcase
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_H0;
      grp_r      <= GRP_HDR;
      mode_r     <= vfp_pkg::MODE_MAP_V1;
      type_r     <= 8'd0;
      cnt_r      <= 7'd0;
      exp_r      <= 7'd0;
      addr_r     <= 7'd0;
      idx_r      <= 3'd0;
      k_r        <= 3'd0;
      wait_r     <= 1'b0;
      sweep_r    <= 1'b0;
      last_r     <= 1'b0;
      cfg_v1_r   <= 8'd1;
      cfg_v2_r   <= 8'd4;
      cfg_pose_r <= 8'd2;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      grp_r      <= grp_nxt;
      mode_r     <= mode_nxt;
      type_r     <= type_nxt;
      cnt_r      <= cnt_nxt;
      exp_r      <= exp_nxt;
      addr_r     <= addr_nxt;
      idx_r      <= idx_nxt;
      k_r        <= k_nxt;
      wait_r     <= wait_nxt;
      sweep_r    <= sweep_nxt;
      last_r     <= last_nxt;
      cfg_v1_r   <= cfg_v1_nxt;
      cfg_v2_r   <= cfg_v2_nxt;
      cfg_pose_r <= cfg_pose_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

// ===== design/vision_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// vision_frame_parser_unit
// Byte-serial sync/type/payload frame parser with XOR checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one received byte per
//   transaction. Header, type and payload bytes are taken while idle and
//   give no records (an unknown type or a full store gives one error).
//   On a frame's last byte the block drops in_ready and walks the payload
//   store once (one read per cycle) to form the checksum, wall popcount and
//   counts, then emits the record run on the output channel (a type or
//   length mismatch or a bad checksum gives one error record instead). An
//   empty cell, header or pose record needs no store read, a filled cell two
//   store reads and a wall word eight; the single store read port sets the
//   pace of the records. out_last marks the final record of a run.
//   A stalled receiver holds the current record in the output register and
//   pauses the sequencer. Reset (rst_n low, synchronous) restarts the sync
//   hunt and restores the default type codes; the payload store is not cleared.
//   cfg_we writes the type code selected by cfg_index; the user is to do so
//   only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module vision_frame_parser_unit #(
  parameter int BOX_SLOTS     = 5,
  parameter int GOAL_SLOTS    = 5,
  parameter int BOMB_SLOTS    = 4,
  parameter int PAYLOAD_DEPTH = 64,
  parameter int WALL_BYTES    = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_record_kind,
  output logic [1:0]         out_error_code,
  output logic [2:0]         out_slot_index,
  output logic signed [15:0] out_value_x,
  output logic signed [15:0] out_value_y,
  output logic signed [15:0] out_heading_x10,
  output logic [63:0]        out_wall_word,
  output logic [2:0]         out_box_total,
  output logic [2:0]         out_goal_total,
  output logic [2:0]         out_bomb_total,
  output logic [7:0]         out_extra,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  vfp_pkg::dp_cmd_t  cmd;
  vfp_pkg::dp_stat_t stat;

  vfp_controller #(
    .BOX_SLOTS    (BOX_SLOTS),
    .GOAL_SLOTS   (GOAL_SLOTS),
    .BOMB_SLOTS   (BOMB_SLOTS),
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .WALL_BYTES   (WALL_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  vfp_datapath #(
    .BOX_SLOTS    (BOX_SLOTS),
    .GOAL_SLOTS   (GOAL_SLOTS),
    .BOMB_SLOTS   (BOMB_SLOTS),
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .wdata         (in_rx_byte),
    .stat          (stat),
    .rec_kind      (out_record_kind),
    .rec_err       (out_error_code),
    .rec_slot      (out_slot_index),
    .rec_x         (out_value_x),
    .rec_y         (out_value_y),
    .rec_heading   (out_heading_x10),
    .rec_wall      (out_wall_word),
    .rec_box_total (out_box_total),
    .rec_goal_total(out_goal_total),
    .rec_bomb_total(out_bomb_total),
    .rec_extra     (out_extra),
    .rec_last      (out_last)
  );

endmodule

// ===== tb/sv/vision_frame_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vision_frame_parser_unit_tb
// Self-checking bench for the frame parser: drives sync/type/payload byte
// streams (well-formed map and pose frames with random content, corrupted
// and truncated frames, noise) through random valid/ready gaps and compares
// every emitted record, field by field, with an in-bench frame predictor.
// ----------------------------------------------------------------------------
module vision_frame_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOX_N  = 5;
  localparam int GOAL_N = 5;
  localparam int BOMB_N = 4;
  localparam int DEPTH  = 64;
  localparam int WALLB  = 24;
  localparam int V2_BOX  = 26;
  localparam int V2_GOAL = V2_BOX + 1 + 2 * BOX_N;
  localparam int V2_BOMB = V2_GOAL + 1 + 2 * GOAL_N;
  localparam int V2_LEN  = V2_BOMB + 1 + 2 * BOMB_N + 7;

  typedef enum logic [1:0] {HUNT_A, HUNT_B, GET_TYPE, GET_DATA} hunt_t;

  typedef struct packed {
    vfp_pkg::rec_kind_t kind;
    vfp_pkg::err_code_t err;
    logic [2:0]  slot;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] hd;
    logic [63:0] wall;
    logic [2:0]  bt;
    logic [2:0]  gt;
    logic [2:0]  mt;
    logic [7:0]  extra;
    logic        last;
  } record_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_record_kind;
  logic [1:0] out_error_code;
  logic [2:0] out_slot_index;
  logic signed [15:0] out_value_x;
  logic signed [15:0] out_value_y;
  logic signed [15:0] out_heading_x10;
  logic [63:0] out_wall_word;
  logic [2:0] out_box_total;
  logic [2:0] out_goal_total;
  logic [2:0] out_bomb_total;
  logic [7:0] out_extra;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = vfp_pkg::CFG_TYPE_MAP_V1;
  logic [7:0] cfg_wdata = '0;

  vision_frame_parser_unit DUT (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [7:0] code_v1 = 8'd1, code_v2 = 8'd4, code_pose = 8'd2;
  hunt_t      phase = HUNT_A;
  logic [7:0] ftype = '0;
  logic [6:0] nbytes = '0;
  logic [6:0] flen = '0;
  logic [7:0] store [DEPTH];

  logic [7:0] byte_queue [$];
  record_t    expected_records [$];
  int         mismatches = 0;
  bit         hold_sender = 1'b0;

  function automatic logic [15:0] sx8(logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  function automatic int clip(int v, int hi);
    return v > hi ? hi : v;
  endfunction

  function automatic record_t blank(vfp_pkg::rec_kind_t k);
    record_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic push_error(vfp_pkg::err_code_t e);
    record_t r;
    r = blank(vfp_pkg::REC_ERROR);
    r.err = e;
    expected_records.push_back(r);
  endtask

  task automatic push_cells(vfp_pkg::rec_kind_t k, int slots, int cnt, int ofs);
    record_t r;
    for (int i = 0; i < slots; i++) begin
      r = blank(k);
      r.slot = i[2:0];
      r.vx = 16'hFFFF;
      r.vy = 16'hFFFF;
      if (i < cnt) begin
        r.vx = sx8(store[(ofs + 2 * i) % DEPTH]);
        r.vy = sx8(store[(ofs + 2 * i + 1) % DEPTH]);
      end
      expected_records.push_back(r);
    end
  endtask

  function automatic bit sum_ok(int len);
    logic [7:0] x;
    x = '0;
    for (int i = 0; i + 1 < len; i++) x ^= store[i];
    return x == store[len - 1];
  endfunction

  task automatic predict_map(bit v2);
    int len, bc, gc, mc, pop, nb, ng, nm;
    record_t r;
    len = v2 ? V2_LEN : 60;
    bc = v2 ? V2_BOX : 26;
    gc = v2 ? V2_GOAL : 35;
    mc = v2 ? V2_BOMB : 44;
    if (!sum_ok(len)) begin
      push_error(vfp_pkg::ERR_CHECKSUM);
      return;
    end
    pop = 0;
    for (int i = 2; i < 26; i++) pop += $countones(store[i]);
    nb = clip(store[bc], BOX_N);
    ng = clip(store[gc], GOAL_N);
    nm = clip(store[mc], BOMB_N);
    r = blank(vfp_pkg::REC_HEADER);
    r.vx = {8'd0, store[0]};
    r.vy = {8'd0, store[1]};
    r.bt = nb[2:0];
    r.gt = ng[2:0];
    r.mt = nm[2:0];
    r.extra = pop[7:0];
    expected_records.push_back(r);
    for (int w = 0; w * 8 < WALLB; w++) begin
      r = blank(vfp_pkg::REC_WALL);
      r.slot = w[2:0];
      for (int k = 0; k < 8; k++)
        if (w * 8 + k < WALLB) r.wall[8*k +: 8] = store[2 + w * 8 + k];
      expected_records.push_back(r);
    end
    push_cells(vfp_pkg::REC_BOX, BOX_N, nb, bc + 1);
    push_cells(vfp_pkg::REC_GOAL, GOAL_N, ng, gc + 1);
    push_cells(vfp_pkg::REC_BOMB, BOMB_N, nm, mc + 1);
  endtask

  task automatic predict_pose();
    int nb, bi, nm, room;
    record_t r;
    if (!sum_ok(26)) begin
      push_error(vfp_pkg::ERR_CHECKSUM);
      return;
    end
    nb = clip(store[7], 5);
    bi = 8 + 2 * nb;
    if (bi >= 25) begin
      push_error(vfp_pkg::ERR_BOMB_FIELD);
      return;
    end
    nm = clip(store[bi], 4);
    room = (25 - (bi + 1)) / 2;
    nm = clip(nm, room);
    push_cells(vfp_pkg::REC_BOX, BOX_N, clip(nb, BOX_N), 8);
    push_cells(vfp_pkg::REC_BOMB, BOMB_N, clip(nm, BOMB_N), bi + 1);
    r = blank(vfp_pkg::REC_POSE);
    r.vx = {store[2], store[1]};
    r.vy = {store[4], store[3]};
    r.hd = {store[6], store[5]};
    r.bt = nb[2:0];
    r.mt = nm[2:0];
    r.extra = store[0];
    expected_records.push_back(r);
  endtask

  task automatic predict_frame_end();
    if (ftype == code_v1) begin
      if (flen == 7'd60) predict_map(1'b0);
      else push_error(vfp_pkg::ERR_FORMAT);
    end else if (ftype == code_v2) begin
      if (flen == 7'(V2_LEN)) predict_map(1'b1);
      else push_error(vfp_pkg::ERR_FORMAT);
    end else if (ftype == code_pose) begin
      if (flen == 7'd26) predict_pose();
      else push_error(vfp_pkg::ERR_FORMAT);
    end else begin
      push_error(vfp_pkg::ERR_FORMAT);
    end
  endtask

  task automatic predict_byte(logic [7:0] b);
    int n_prior;
    n_prior = expected_records.size();
    case (phase)
      HUNT_A: if (b == vfp_pkg::SYNC_A) phase = HUNT_B;
      HUNT_B: begin
        if (b == vfp_pkg::SYNC_B) phase = GET_TYPE;
        else if (b != vfp_pkg::SYNC_A) phase = HUNT_A;
      end
      GET_TYPE: begin
        ftype = b;
        nbytes = '0;
        phase = GET_DATA;
        if (b == code_v1) flen = 7'd60;
        else if (b == code_v2) flen = 7'(V2_LEN);
        else if (b == code_pose) flen = 7'd26;
        else begin
          phase = HUNT_A;
          push_error(vfp_pkg::ERR_FORMAT);
        end
      end
      default: begin
        if (nbytes >= 7'(DEPTH)) begin
          phase = HUNT_A;
          push_error(vfp_pkg::ERR_FORMAT);
        end else begin
          store[nbytes[5:0]] = b;
          nbytes = nbytes + 7'd1;
          if (flen != 0 && nbytes >= flen) begin
            predict_frame_end();
            phase = HUNT_A;
          end
        end
      end
    endcase
    if (expected_records.size() > n_prior)
      expected_records[expected_records.size() - 1].last = 1'b1;
  endtask

  // sender: hold each byte until taken, random gap between bytes
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else begin
      if (in_valid) begin
        predict_byte(in_rx_byte);
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_rx_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, compare each record with the oldest expectation
  int recv_gap = 0;
  always @(posedge clk) begin
    record_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind = vfp_pkg::rec_kind_t'(out_record_kind);
        got.err = vfp_pkg::err_code_t'(out_error_code);
        got.slot = out_slot_index;
        got.vx = out_value_x;
        got.vy = out_value_y;
        got.hd = out_heading_x10;
        got.wall = out_wall_word;
        got.bt = out_box_total;
        got.gt = out_goal_total;
        got.mt = out_bomb_total;
        got.extra = out_extra;
        got.last = out_last;
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %p", got);
        end else begin
          want = expected_records.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("record mismatch: exp %p got %p", want, got);
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_frame(logic [7:0] code, int len, int kind_sel, int corrupt);
    logic [7:0] p [DEPTH];
    logic [7:0] x;
    int n_send;
    for (int i = 0; i < DEPTH; i++) p[i] = 8'($urandom);
    // mostly small counts so that both filled and empty slots show up
    if (kind_sel == 0) begin
      p[26] = 8'($urandom_range(0, 7));
      p[35] = 8'($urandom_range(0, 7));
      p[44] = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) p[26] = 8'($urandom);
    end else if (kind_sel == 1) begin
      p[V2_BOX] = 8'($urandom_range(0, 7));
      p[V2_GOAL] = 8'($urandom_range(0, 7));
      p[V2_BOMB] = 8'($urandom_range(0, 7));
    end else begin
      p[7] = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 5));
      p[8 + 2 * clip(p[7], 5)] = 8'($urandom_range(0, 6));
    end
    x = '0;
    for (int i = 0; i + 1 < len; i++) x ^= p[i];
    p[len - 1] = corrupt == 1 ? x ^ 8'($urandom_range(1, 255)) : x;
    if ($urandom_range(0, 2) == 0) byte_queue.push_back(vfp_pkg::SYNC_A);
    byte_queue.push_back(vfp_pkg::SYNC_A);
    byte_queue.push_back(vfp_pkg::SYNC_B);
    byte_queue.push_back(code);
    // truncated frame: cut short, a new sync then shows up as payload
    n_send = corrupt == 2 ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < n_send; i++)
      byte_queue.push_back(p[i]);
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > 0 || in_valid || expected_records.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_code(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vfp_pkg::CFG_TYPE_MAP_V1: code_v1 = val;
      vfp_pkg::CFG_TYPE_MAP_V2: code_v2 = val;
      default: code_pose = val;
    endcase
  endtask

  task automatic random_traffic(int n_items);
    int sel, target;
    target = byte_queue.size() + n_items;
    while (byte_queue.size() < target) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) add_frame(code_pose, 26, 2, $urandom_range(0, 5) == 0 ? 1 : 0);
      else if (sel < 5) add_frame(code_v1, 60, 0, $urandom_range(0, 5) == 0 ? 1 : 0);
      else if (sel < 6) add_frame(code_v2, V2_LEN, 1, 0);
      else if (sel < 7) add_frame(code_pose, 26, 2, 2);
      else if (sel < 8) begin
        byte_queue.push_back(vfp_pkg::SYNC_A);
        byte_queue.push_back(vfp_pkg::SYNC_B);
        byte_queue.push_back(8'($urandom));
      end else begin
        for (int i = 0; i < 6; i++) byte_queue.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] pz [26];
    for (int i = 0; i < DEPTH; i++) store[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise extremes, repeated sync, unknown type, map v1 and pose frames
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(vfp_pkg::SYNC_A);
    byte_queue.push_back(vfp_pkg::SYNC_A);
    byte_queue.push_back(vfp_pkg::SYNC_B);
    byte_queue.push_back(8'hFF);
    add_frame(8'd1, 60, 0, 0);
    add_frame(8'd2, 26, 2, 0);
    add_frame(8'd2, 26, 2, 1);
    // pose with box count above its limit and bomb count clamped to the room
    for (int i = 0; i < 26; i++) pz[i] = 8'h80;
    pz[7] = 8'd9;
    pz[18] = 8'hFF;
    pz[25] = '0;
    for (int i = 0; i < 25; i++) pz[25] ^= pz[i];
    byte_queue.push_back(vfp_pkg::SYNC_A);
    byte_queue.push_back(vfp_pkg::SYNC_B);
    byte_queue.push_back(8'd2);
    foreach (pz[i]) byte_queue.push_back(pz[i]);
    wait_drained();

    // v2 frame fills the whole store
    add_frame(8'd4, V2_LEN, 1, 0);
    random_traffic(20);
    wait_drained();

    // colliding codes: map v1 wins, v2 unreachable on that code; pose moves to 8'hFF
    write_code(vfp_pkg::CFG_TYPE_MAP_V1, 8'd0);
    write_code(vfp_pkg::CFG_TYPE_MAP_V2, 8'd0);
    write_code(vfp_pkg::CFG_TYPE_POSE, 8'hFF);
    add_frame(8'd0, 60, 0, 0);
    add_frame(8'hFF, 26, 2, 0);
    random_traffic(20);
    // stop feeding until every record has drained
    hold_sender = 1'b1;
    while (in_valid || expected_records.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    write_code(vfp_pkg::CFG_TYPE_MAP_V1, 8'hFF);
    write_code(vfp_pkg::CFG_TYPE_MAP_V2, 8'h5A);
    write_code(vfp_pkg::CFG_TYPE_POSE, 8'hA5);
    random_traffic(20);
    wait_drained();

    write_code(vfp_pkg::CFG_TYPE_MAP_V1, 8'd1);
    write_code(vfp_pkg::CFG_TYPE_MAP_V2, 8'd4);
    write_code(vfp_pkg::CFG_TYPE_POSE, 8'd2);
    random_traffic(20);
    wait_drained();

    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule
